>>> sv/tsup_pkg.sv
package tsup_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ALPHABET   = 26;
  localparam int MAX_WORD   = 255;

  localparam int NODE_W   = $clog2(NODE_COUNT);
  localparam int FREE_W   = NODE_W + 1;
  localparam int CNT_W    = 2;
  localparam int CNT_MAX  = 2;
  localparam int LETTER_W = 5;
  localparam int CH_W     = $clog2(ALPHABET);
  localparam int POS_W    = $clog2(MAX_WORD + 1);
  localparam int LEN_W    = 8;
  localparam int STAT_W   = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // one child slot of a node row; cnt is the pass count of the child node
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [NODE_W-1:0] link;
  } slot_t;

  typedef slot_t [ALPHABET-1:0] row_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam int ROW_W  = $bits(row_t);

endpackage

>>> sv/tsup_ram.sv
module tsup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/trie_shortest_unique_prefix_unit.sv
// Shortest-unique-prefix trie, one letter per transaction.
// Input: start with in_op (0 insert, 1 query), in_letter (0..25, larger values
// wrap by 26) and in_last. A transaction is taken at a clock edge with start
// high and busy low. After each transaction busy is high for one cycle.
// Output: in the cycle after the transaction's execute cycle, a word's
// last letter raises out_valid for exactly one cycle with out_kind,
// out_prefix_length and out_status (0 ok, 1 query path missing, 2 pool full).
// A new letter is not taken until the last one has finished the read-modify-write
// of the current node's row in the node memory (registered read, then write back).
// The node memory holds one row per node; each slot carries the child link and
// the child's pass count, so a letter needs a single row access.
// Reset: a clearing pass writes zero to all NODE_COUNT rows, busy is high
// throughout; the pool then restarts at node one.
// The receiver cannot stall: each result is on the ports for one cycle only.
module trie_shortest_unique_prefix_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [tsup_pkg::LETTER_W-1:0] in_letter,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [tsup_pkg::LEN_W-1:0]   out_prefix_length,
  output logic [tsup_pkg::STAT_W-1:0]  out_status
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [tsup_pkg::NODE_W-1:0]   clr_r, clr_nxt;
  logic                          op_r, last_r;
  logic [tsup_pkg::CH_W-1:0]     ch_r;
  logic [tsup_pkg::CH_W-1:0]     ch_in;
  logic [tsup_pkg::NODE_W-1:0]   cursor_r, cursor_nxt;
  logic [tsup_pkg::POS_W-1:0]    pos_r, pos_nxt, pos_inc;
  logic                          found_r, found_nxt;
  logic [tsup_pkg::POS_W-1:0]    alen_r, alen_nxt;
  logic [tsup_pkg::STAT_W-1:0]   err_r, err_nxt;
  logic [tsup_pkg::FREE_W-1:0]   free_r, free_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic [tsup_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [tsup_pkg::STAT_W-1:0]   out_stat_r, out_stat_nxt;

  logic                          accept;
  logic                          ram_we;
  logic [tsup_pkg::NODE_W-1:0]   ram_waddr;
  logic [tsup_pkg::ROW_W-1:0]    ram_wdata;
  logic [tsup_pkg::ROW_W-1:0]    ram_rdata;
  tsup_pkg::row_t                row_rd, row_wr;
  tsup_pkg::slot_t               slot;
  logic [tsup_pkg::POS_W-1:0]    len_sel;
  logic                          exec_we;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign ch_in = (in_letter >= tsup_pkg::LETTER_W'(tsup_pkg::ALPHABET))
               ? tsup_pkg::CH_W'(in_letter - tsup_pkg::LETTER_W'(tsup_pkg::ALPHABET))
               : tsup_pkg::CH_W'(in_letter);

  tsup_ram #(
    .WIDTH(tsup_pkg::ROW_W),
    .DEPTH(tsup_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cursor_r),
    .rdata(ram_rdata)
  );

  assign row_rd    = ram_rdata;
  assign slot      = row_rd[ch_r];
  assign ram_we    = (state_r == S_CLEAR) || exec_we;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : cursor_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : row_wr;

  assign pos_inc = (pos_r < tsup_pkg::POS_W'(tsup_pkg::MAX_WORD))
                 ? pos_r + tsup_pkg::POS_W'(1) : pos_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cursor_nxt    = cursor_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    alen_nxt      = alen_r;
    err_nxt       = err_r;
    free_nxt      = free_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_len_nxt   = out_len_r;
    out_stat_nxt  = out_stat_r;
    row_wr        = row_rd;
    exec_we       = 1'b0;
    len_sel       = '0;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + tsup_pkg::NODE_W'(1);
        if (clr_r == tsup_pkg::NODE_W'(tsup_pkg::NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        pos_nxt   = pos_inc;
        if (err_r == tsup_pkg::ST_OK) begin
          if (op_r == tsup_pkg::OP_INSERT) begin
            if (slot.link == '0) begin
              if (free_r >= tsup_pkg::FREE_W'(tsup_pkg::NODE_COUNT)) begin
                err_nxt = tsup_pkg::ST_FULL;
              end else begin
                row_wr[ch_r].link = free_r[tsup_pkg::NODE_W-1:0];
                row_wr[ch_r].cnt  = tsup_pkg::CNT_W'(1);
                free_nxt   = free_r + tsup_pkg::FREE_W'(1);
                cursor_nxt = free_r[tsup_pkg::NODE_W-1:0];
                exec_we    = 1'b1;
              end
            end else begin
              if (slot.cnt < tsup_pkg::CNT_W'(tsup_pkg::CNT_MAX)) begin
                row_wr[ch_r].cnt = slot.cnt + tsup_pkg::CNT_W'(1);
              end
              cursor_nxt = slot.link;
              exec_we    = 1'b1;
            end
          end else begin
            if (slot.link == '0) begin
              err_nxt = tsup_pkg::ST_MISSING;
            end else begin
              cursor_nxt = slot.link;
              if (!found_r && slot.cnt == tsup_pkg::CNT_W'(1)) begin
                found_nxt = 1'b1;
                alen_nxt  = pos_inc;
              end
            end
          end
        end

        if (last_r) begin
          if (op_r == tsup_pkg::OP_INSERT) begin
            len_sel = pos_inc;
          end else if (err_nxt != tsup_pkg::ST_OK) begin
            len_sel = '0;
          end else begin
            len_sel = found_nxt ? alen_nxt : pos_inc;
          end
          out_valid_nxt = 1'b1;
          out_kind_nxt  = op_r;
          out_len_nxt   = tsup_pkg::LEN_W'(len_sel);
          out_stat_nxt  = err_nxt;
          cursor_nxt    = '0;
          pos_nxt       = '0;
          found_nxt     = 1'b0;
          alen_nxt      = '0;
          err_nxt       = tsup_pkg::ST_OK;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cursor_r    <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      alen_r      <= '0;
      err_r       <= tsup_pkg::ST_OK;
      free_r      <= tsup_pkg::FREE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cursor_r    <= cursor_nxt;
      pos_r       <= pos_nxt;
      found_r     <= found_nxt;
      alen_r      <= alen_nxt;
      err_r       <= err_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      ch_r   <= ch_in;
      last_r <= in_last;
    end
    out_kind_r <= out_kind_nxt;
    out_len_r  <= out_len_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_prefix_length = out_len_r;
  assign out_status        = out_stat_r;

  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC && last_r))
    else $error("result strobe without a finished word");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted transaction not executed");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= tsup_pkg::FREE_W'(tsup_pkg::NODE_COUNT))
    else $error("free node pointer past pool");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != S_IDLE)
    else $error("node memory written while idle");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && err_r != tsup_pkg::ST_OK) |-> !ram_we)
    else $error("node memory written after word error");

endmodule

>>> test/tb_trie_shortest_unique_prefix_unit.sv
`timescale 1ns / 1ps

module tb_trie_shortest_unique_prefix_unit;
  import tsup_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_LETTERS = 120;
  localparam int LONG_LEN = 260;
  localparam int DICT_SIZE = 64;
  localparam int DICT_WORD = 8;

  typedef struct packed {
    logic              kind;
    logic [LEN_W-1:0]  plen;
    logic [STAT_W-1:0] status;
  } answer_t;

  // Trie mirror plus the queue of answers still owed by the block.
  class prefix_scoreboard;
    logic [NODE_W-1:0] links [NODE_COUNT*ALPHABET];
    logic [CNT_W-1:0]  counts [NODE_COUNT];
    int unsigned       free_node;
    int unsigned       cursor;
    int unsigned       depth;
    int unsigned       hit_depth;
    bit                hit;
    logic [STAT_W-1:0] err;
    answer_t           pending_answers[$];
    int                mismatches;

    function new();
      foreach (links[i]) links[i] = '0;
      foreach (counts[i]) counts[i] = '0;
      free_node = 1;
      mismatches = 0;
      restart_word();
    endfunction

    function void restart_word();
      cursor = 0;
      depth = 0;
      hit = 0;
      hit_depth = 0;
      err = ST_OK;
    endfunction

    function void note_letter(logic op, logic [LETTER_W-1:0] letter, logic is_last);
      int unsigned       slot;
      logic [NODE_W-1:0] child;
      answer_t           a;
      if (depth < MAX_WORD) depth++;
      if (err == ST_OK) begin
        slot = cursor * ALPHABET + (letter % ALPHABET);
        child = links[slot];
        if (op == OP_INSERT) begin
          if (child == 0) begin
            if (free_node >= NODE_COUNT) begin
              err = ST_FULL;
            end else begin
              child = free_node[NODE_W-1:0];
              free_node++;
              links[slot] = child;
            end
          end
          if (err == ST_OK) begin
            cursor = child;
            if (counts[child] < CNT_MAX) counts[child] = counts[child] + 1'b1;
          end
        end else begin
          if (child == 0) begin
            err = ST_MISSING;
          end else begin
            cursor = child;
            if (!hit && counts[child] == 1) begin
              hit = 1;
              hit_depth = depth;
            end
          end
        end
      end
      if (is_last) begin
        a.kind = op;
        a.status = err;
        if (op == OP_INSERT) a.plen = LEN_W'(depth);
        else if (err != ST_OK) a.plen = '0;
        else a.plen = hit ? LEN_W'(hit_depth) : LEN_W'(depth);
        pending_answers.push_back(a);
        restart_word();
      end
    endfunction

    function void report(string msg);
      if (mismatches < 10) $display("%t: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void check_answer(logic kind, logic [LEN_W-1:0] plen, logic [STAT_W-1:0] status);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected result kind=%0d len=%0d status=%0d",
                         kind, plen, status));
      end else begin
        want = pending_answers.pop_front();
        if (kind !== want.kind || plen !== want.plen || status !== want.status)
          report($sformatf("expected kind=%0d len=%0d status=%0d, got kind=%0d len=%0d status=%0d",
                           want.kind, want.plen, want.status, kind, plen, status));
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                in_op = OP_INSERT;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                in_last = 1'b0;
  logic                busy;
  logic                out_valid;
  logic                out_kind;
  logic [LEN_W-1:0]    out_prefix_length;
  logic [STAT_W-1:0]   out_status;

  prefix_scoreboard sb = new();

  logic [LETTER_W-1:0] word_buf [LONG_LEN];
  int                  word_len;
  logic [LETTER_W-1:0] dict [DICT_SIZE][DICT_WORD];
  int                  dict_len [DICT_SIZE];
  int                  dict_count = 0;
  int                  sent_letters = 0;
  int                  idle_cycles = 0;

  trie_shortest_unique_prefix_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_letter         (in_letter),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_prefix_length (out_prefix_length),
    .out_status        (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_answer(out_kind, out_prefix_length, out_status);
      if (start && !busy) sb.note_letter(in_op, in_letter, in_last);
    end
  end

  // nothing accepted on either side for too long; covers the clearing pass
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // start stays high across back-to-back letters; dropped only for a gap
  task automatic send_letter(input logic op, input logic [LETTER_W-1:0] letter,
                             input logic is_last);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_letter <= letter;
    in_last <= is_last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_letters++;
  endtask

  task automatic send_word(input logic op);
    for (int i = 0; i < word_len; i++) send_letter(op, word_buf[i], i == word_len - 1);
  endtask

  task automatic send_text(input logic op, input string s);
    for (int i = 0; i < s.len(); i++)
      send_letter(op, LETTER_W'(s[i] - "a"), i == s.len() - 1);
  endtask

  task automatic make_word(input int len, input int span);
    word_len = len;
    for (int i = 0; i < len; i++) word_buf[i] = LETTER_W'($urandom_range(0, span));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int k;
    int words;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_text(OP_QUERY, "a");              // empty tree: path missing
    send_text(OP_INSERT, "abc");
    send_text(OP_INSERT, "abd");
    send_text(OP_QUERY, "abc");
    send_text(OP_QUERY, "ab");             // no depth with count one
    send_text(OP_INSERT, "z");
    send_letter(OP_INSERT, 5'd31, 1'b0);   // out-of-range letters wrap
    send_letter(OP_INSERT, 5'd26, 1'b1);
    send_text(OP_QUERY, "fa");
    send_letter(OP_INSERT, 5'd16, 1'b0);   // mixed ops in one word
    send_letter(OP_QUERY, 5'd23, 1'b1);
    send_letter(OP_QUERY, 5'd0, 1'b0);
    send_letter(OP_INSERT, 5'd1, 1'b1);
    send_text(OP_QUERY, "ybc");            // error set, rest only counts length

    // random words, mostly well formed over a narrow alphabet
    words = 0;
    while (sent_letters < RANDOM_LETTERS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 || dict_count == 0) begin
        make_word($urandom_range(1, 6), ($urandom_range(0, 7) == 0) ? 31 : 3);
        k = dict_count % DICT_SIZE;
        for (int i = 0; i < word_len; i++) dict[k][i] = word_buf[i];
        dict_len[k] = word_len;
        dict_count++;
        send_word(OP_INSERT);
      end else if (pick < 8) begin
        k = $urandom_range(0, ((dict_count < DICT_SIZE) ? dict_count : DICT_SIZE) - 1);
        word_len = $urandom_range(0, 1) ? dict_len[k] : $urandom_range(1, dict_len[k]);
        for (int i = 0; i < word_len; i++) word_buf[i] = dict[k][i];
        send_word(OP_QUERY);
      end else if (pick == 8) begin
        make_word($urandom_range(1, 4), 31);
        send_word(OP_QUERY);
      end else begin
        word_len = $urandom_range(1, 5);
        for (int i = 0; i < word_len; i++)
          send_letter(logic'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)),
                      i == word_len - 1);
      end
      words++;
      if (words == 10) wait_drained();
    end

    // long word: length saturates
    make_word(LONG_LEN, 25);
    send_word(OP_INSERT);
    make_word(3, 31);
    send_word(OP_QUERY);

    start <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> trie_shortest_unique_prefix_unit.f
sv/tsup_pkg.sv
sv/tsup_ram.sv
sv/trie_shortest_unique_prefix_unit.sv
test/tb_trie_shortest_unique_prefix_unit.sv
